@@ rtl/tpq_pkg.sv @@
// tpq_pkg: shared types, codes and helper functions for the tag presence qualifier.
// Used by tpq_cfg, tpq_state and tag_presence_qualifier; depends on nothing.
package tpq_pkg;

    localparam int UID_BYTES = 7;
    localparam int UID_W     = 8 * UID_BYTES;
    localparam int LEN_W     = 3;
    localparam int HIT_W     = 8;
    localparam int GRACE_W   = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    // Scan result codes
    localparam logic [1:0] SCAN_MISS  = 2'd0;
    localparam logic [1:0] SCAN_FOUND = 2'd1;
    localparam logic [1:0] SCAN_FAIL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_HITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_HITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_GRACE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_RECOV  = 2'd3;

    typedef struct packed {
        logic [1:0]        scan_result;
        logic [UID_W-1:0]  uid;
        logic [LEN_W-1:0]  uid_len;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic              present;
        logic              changed;
        logic [UID_W-1:0]  tag_uid;
        logic [LEN_W-1:0]  tag_len;
        logic              reader_restart;
    } out_word_t;

    typedef struct packed {
        logic [HIT_W-1:0]   confirm_reads;
        logic [HIT_W-1:0]   absent_reads;
        logic [GRACE_W-1:0] absent_grace_ms;
        logic [GRACE_W-1:0] empty_recovery_ms;
    } cfg_t;

    // Keep only the bytes below len.
    function automatic logic [UID_W-1:0] uid_mask(input logic [LEN_W-1:0] len);
        logic [UID_W-1:0] m;
        m = '0;
        for (int i = 0; i < UID_BYTES; i++)
        begin
            if ((LEN_W+1)'(i) < {1'b0, len})
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [HIT_W-1:0] sat_inc(input logic [HIT_W-1:0] v);
        return (v == HIT_MAX) ? HIT_MAX : v + HIT_W'(1);
    endfunction

endpackage

@@ rtl/tag_presence_qualifier.sv @@
// tag_presence_qualifier: top level with input and result registers around tpq_state.
// Depends on tpq_pkg, tpq_cfg and tpq_state.
//
// Debounces reader polls into a confirmed tag presence. Each accepted poll word
// yields exactly one result word. A poll is captured in an input register, the
// presence state is updated from it, and the result lands in an output
// register; a new poll is accepted every cycle as long as the result register
// is free or being drained, so sustained throughput is one word per clock. The
// state update, with its 32-bit elapsed-time subtracts and compares, is
// combinational between the input and output registers. Configuration writes
// take effect at once and should be issued only while no poll is in flight.
module tag_presence_qualifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  tpq_pkg::in_word_t             item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output tpq_pkg::out_word_t            result,
    input  logic                          cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpq_pkg::CFG_W-1:0]     cfg_data
);
    import tpq_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;
    out_word_t result_next;
    cfg_t      cfg;
    logic      advance;
    logic      take;

    tpq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpq_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (s1_word_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Advance the held poll when the result register is empty or draining.
    assign advance    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next  = take || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_word_reg <= item;
        end
        if (advance)
        begin
            out_word_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // Back pressure only comes from a stalled, full result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (s1_valid_reg && out_valid_reg && !result_ready))
        else $error("input stalled without a blocked result");

    a_present_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.present == (result.tag_len != '0)))
        else $error("result presence and length disagree");

    a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.reader_restart) |-> (!result.present && !result.changed))
        else $error("reader restart raised while a tag is held");

endmodule

@@ rtl/tpq_cfg.sv @@
// tpq_cfg: configuration register file of the tag presence qualifier.
// Depends on tpq_pkg for the register indexes and the cfg_t struct.
module tpq_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpq_pkg::CFG_W-1:0]     cfg_data,
    output tpq_pkg::cfg_t                 cfg
);
    import tpq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESENT_HITS: cfg_next.confirm_reads     = cfg_data[HIT_W-1:0];
                CFG_REMOVE_HITS:  cfg_next.absent_reads      = cfg_data[HIT_W-1:0];
                CFG_REMOVE_GRACE: cfg_next.absent_grace_ms   = cfg_data[GRACE_W-1:0];
                CFG_EMPTY_RECOV:  cfg_next.empty_recovery_ms = cfg_data[GRACE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_reads     <= HIT_W'(1);
            cfg_reg.absent_reads      <= HIT_W'(3);
            cfg_reg.absent_grace_ms   <= GRACE_W'(500);
            cfg_reg.empty_recovery_ms <= GRACE_W'(2500);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tpq_state.sv @@
// tpq_state: presence state registers and the one-word update logic.
// Depends on tpq_pkg; the result word is combinational, registered by the top level.
module tpq_state (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tpq_pkg::in_word_t  item,
    input  tpq_pkg::cfg_t      cfg,
    output tpq_pkg::out_word_t result_next
);
    import tpq_pkg::*;

    logic              is_present_reg,      is_present_next;
    logic [UID_W-1:0]  confirmed_uid_reg,   confirmed_uid_next;
    logic [LEN_W-1:0]  confirmed_len_reg,   confirmed_len_next;
    logic [UID_W-1:0]  candidate_uid_reg,   candidate_uid_next;
    logic [LEN_W-1:0]  candidate_len_reg,   candidate_len_next;
    logic [HIT_W-1:0]  candidate_count_reg, candidate_count_next;
    logic [HIT_W-1:0]  miss_count_reg,      miss_count_next;
    logic [TIME_W-1:0] last_seen_reg,       last_seen_next;
    logic [TIME_W-1:0] last_restart_reg,    last_restart_next;

    logic [LEN_W-1:0]  len_c;
    logic [UID_W-1:0]  uid_m;
    logic              is_found;
    logic              is_miss;
    logic              match_conf;
    logic              match_cand;
    logic [HIT_W-1:0]  cand_hits;
    logic [HIT_W-1:0]  miss_hits;
    logic [TIME_W-1:0] since_seen;
    logic [TIME_W-1:0] since_restart;
    logic              restart;

    always_comb
    begin
        // Clamp the length, zero the bytes above it.
        if ({1'b0, item.uid_len} > (LEN_W+1)'(UID_BYTES))
        begin
            len_c = LEN_W'(UID_BYTES);
        end
        else
        begin
            len_c = item.uid_len;
        end
        uid_m = item.uid & uid_mask(len_c);

        // Found with zero length and the unused code count as read failure.
        is_found = (item.scan_result == SCAN_FOUND) && (len_c != '0);
        is_miss  = (item.scan_result == SCAN_MISS);

        // Stored identifiers are already masked, so whole-word compares suffice.
        match_conf = (len_c == confirmed_len_reg) && (uid_m == confirmed_uid_reg);
        match_cand = (len_c == candidate_len_reg) && (uid_m == candidate_uid_reg);

        cand_hits     = match_cand ? sat_inc(candidate_count_reg) : HIT_W'(1);
        miss_hits     = sat_inc(miss_count_reg);
        since_seen    = item.now_ms - last_seen_reg;
        since_restart = item.now_ms - last_restart_reg;

        is_present_next      = is_present_reg;
        confirmed_uid_next   = confirmed_uid_reg;
        confirmed_len_next   = confirmed_len_reg;
        candidate_uid_next   = candidate_uid_reg;
        candidate_len_next   = candidate_len_reg;
        candidate_count_next = candidate_count_reg;
        miss_count_next      = miss_count_reg;
        last_seen_next       = last_seen_reg;
        last_restart_next    = last_restart_reg;
        restart              = 1'b0;

        priority if (is_found)
        begin
            last_restart_next = item.now_ms;
            miss_count_next   = '0;
            if (is_present_reg && match_conf)
            begin
                last_seen_next       = item.now_ms;
                candidate_count_next = '0;
            end
            else if (is_present_reg && !match_cand)
            begin
                candidate_uid_next   = uid_m;
                candidate_len_next   = len_c;
                candidate_count_next = HIT_W'(1);
            end
            else
            begin
                candidate_uid_next   = uid_m;
                candidate_len_next   = len_c;
                candidate_count_next = cand_hits;
                if (cand_hits >= cfg.confirm_reads)
                begin
                    confirmed_uid_next   = uid_m;
                    confirmed_len_next   = len_c;
                    last_seen_next       = item.now_ms;
                    candidate_count_next = '0;
                    is_present_next      = 1'b1;
                end
            end
        end
        else if (is_miss)
        begin
            candidate_count_next = '0;
            if (is_present_reg)
            begin
                miss_count_next = miss_hits;
                if ((miss_hits >= cfg.absent_reads)
                    && (since_seen >= TIME_W'(cfg.absent_grace_ms)))
                begin
                    confirmed_uid_next = '0;
                    confirmed_len_next = '0;
                    candidate_uid_next = '0;
                    candidate_len_next = '0;
                    miss_count_next    = '0;
                    is_present_next    = 1'b0;
                end
            end
            else if (since_restart >= TIME_W'(cfg.empty_recovery_ms))
            begin
                last_restart_next = item.now_ms;
                restart           = 1'b1;
            end
        end
        else
        begin
            candidate_count_next = '0;
        end

        result_next.present        = is_present_next;
        result_next.changed        = is_present_next ^ is_present_reg;
        result_next.tag_uid        = confirmed_uid_next;
        result_next.tag_len        = confirmed_len_next;
        result_next.reader_restart = restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_present_reg      <= 1'b0;
            confirmed_uid_reg   <= '0;
            confirmed_len_reg   <= '0;
            candidate_uid_reg   <= '0;
            candidate_len_reg   <= '0;
            candidate_count_reg <= '0;
            miss_count_reg      <= '0;
            last_seen_reg       <= '0;
            last_restart_reg    <= '0;
        end
        else if (step)
        begin
            is_present_reg      <= is_present_next;
            confirmed_uid_reg   <= confirmed_uid_next;
            confirmed_len_reg   <= confirmed_len_next;
            candidate_uid_reg   <= candidate_uid_next;
            candidate_len_reg   <= candidate_len_next;
            candidate_count_reg <= candidate_count_next;
            miss_count_reg      <= miss_count_next;
            last_seen_reg       <= last_seen_next;
            last_restart_reg    <= last_restart_next;
        end
    end

    // A confirmed tag always has a nonzero length; an empty reader holds none.
    a_present_len: assert property (@(posedge clk) disable iff (!rst_n)
        is_present_reg == (confirmed_len_reg != '0))
        else $error("presence flag and confirmed length disagree");

    a_empty_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !is_present_reg |-> (miss_count_reg == '0))
        else $error("miss count nonzero while empty");

    a_empty_uid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !is_present_reg |-> (confirmed_uid_reg == '0))
        else $error("confirmed identifier kept while empty");

endmodule
